@@ rtl/mrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants for the mapped region table.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int SLOTS     = 16;
  localparam int PAGE_BITS = 12;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int ADDR_W = 38;
  localparam int LEN_W  = 31;
  localparam int PROT_W = 3;
  localparam int FLAG_W = 2;
  localparam int FILE_W = 6;
  localparam int STAT_W = 3;

  localparam logic [ADDR_W-1:0] CEIL_RESET = 38'h3F_FFFF_E000;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_WRITE_DENIED = 3'd1,
    ST_NO_SLOT      = 3'd2,
    ST_NO_ROOM      = 3'd3,
    ST_NOT_MAPPED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_CALC,
    S_MAP_CHECK,
    S_UN_READ,
    S_UN_CHECK,
    S_UN_UPDATE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic [PROT_W-1:0] prot;
    logic [FLAG_W-1:0] flags;
    logic [FILE_W-1:0] file;
  } slot_t;

  typedef struct packed {
    logic    load;
    logic    calc;
    logic    map_commit;
    logic    mem_rd;
    logic    scan_next;
    logic    unmap_commit;
    logic    res_valid;
    status_t res_status;
  } mrt_cmd_t;

  typedef struct packed {
    logic is_unmap;
    logic denied;
    logic no_free;
    logic no_room;
    logic hit;
    logic last;
  } mrt_stat_t;

endpackage

@@ rtl/mrt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_datapath
// Request registers, slot store, ceiling arithmetic and result registers.
// ----------------------------------------------------------------------------
module mrt_datapath
  import mrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mrt_cmd_t          cmd,
  output mrt_stat_t         stat,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data,
  input  logic              in_func,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [LEN_W-1:0]  in_length,
  input  logic [PROT_W-1:0] in_protection,
  input  logic [FLAG_W-1:0] in_map_flags,
  input  logic              in_file_writable,
  input  logic [FILE_W-1:0] in_file_handle,
  input  logic [ADDR_W-1:0] in_heap_top,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_region_start,
  output logic              out_close_file,
  output logic [FILE_W-1:0] out_closed_handle,
  output logic              out_writeback_needed
);

  slot_t             mem [SLOTS];
  slot_t             rd_data_r;
  logic [SLOTS-1:0]  used_r;
  logic [ADDR_W-1:0] ceiling_r;

  logic              func_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;
  logic [PROT_W-1:0] prot_r;
  logic [FLAG_W-1:0] flags_r;
  logic              fwr_r;
  logic [FILE_W-1:0] fh_r;
  logic [ADDR_W-1:0] heap_r;

  logic [SLOT_W-1:0] idx_r;
  logic [SLOT_W-1:0] free_idx_r;
  logic [SLOT_W-1:0] free_idx;
  logic              no_free_r;
  logic              no_free;
  logic [ADDR_W-1:0] nc_r;
  logic              under_r;

  logic [ADDR_W:0]   diff;
  logic [ADDR_W-1:0] len_ext;
  logic [ADDR_W:0]   slot_end;
  logic              exact;
  slot_t             wr_slot;

  logic [STAT_W-1:0] status_r;
  logic [ADDR_W-1:0] region_start_r;
  logic              close_r;
  logic [FILE_W-1:0] handle_r;
  logic              wb_r;

  assign len_ext  = {{(ADDR_W-LEN_W){1'b0}}, len_r};
  assign diff     = {1'b0, ceiling_r} - {1'b0, len_ext};
  assign slot_end = {1'b0, rd_data_r.start}
                  + {{(ADDR_W-LEN_W+1){1'b0}}, rd_data_r.length};
  assign exact    = (addr_r == rd_data_r.start) && (len_r == rd_data_r.length);

  always_comb begin
    free_idx = '0;
    no_free  = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = SLOT_W'(i);
        no_free  = 1'b0;
      end
    end
  end

  always_comb begin
    stat.is_unmap = func_r;
    stat.denied   = flags_r[0] && prot_r[1] && !fwr_r;
    stat.no_free  = no_free_r;
    stat.no_room  = under_r || (nc_r < heap_r);
    stat.hit      = used_r[idx_r] && (addr_r >= rd_data_r.start)
                 && ({1'b0, addr_r} < slot_end);
    stat.last     = (idx_r == SLOT_W'(SLOTS - 1));
  end

  always_comb begin
    if (cmd.map_commit) begin
      wr_slot.start  = nc_r;
      wr_slot.length = len_r;
      wr_slot.prot   = prot_r;
      wr_slot.flags  = flags_r;
      wr_slot.file   = fh_r;
    end else begin
      wr_slot        = rd_data_r;
      if (addr_r == rd_data_r.start) begin
        wr_slot.start = rd_data_r.start + len_ext;
      end
      wr_slot.length = (len_r >= rd_data_r.length) ? '0 : rd_data_r.length - len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_commit) begin
      mem[free_idx_r] <= wr_slot;
    end else if (cmd.unmap_commit && !exact) begin
      mem[idx_r] <= wr_slot;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      ceiling_r <= CEIL_RESET;
    end else begin
      if (cfg_wr_en) begin
        ceiling_r <= cfg_wr_data;
      end else if (cmd.map_commit) begin
        ceiling_r <= nc_r;
      end
      if (cmd.map_commit) begin
        used_r[free_idx_r] <= 1'b1;
      end else if (cmd.unmap_commit && exact) begin
        used_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.scan_next) begin
      idx_r <= idx_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      addr_r  <= in_address;
      len_r   <= in_length;
      prot_r  <= in_protection;
      flags_r <= in_map_flags;
      fwr_r   <= in_file_writable;
      fh_r    <= in_file_handle;
      heap_r  <= in_heap_top;
    end
    if (cmd.calc) begin
      nc_r       <= {diff[ADDR_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
      under_r    <= diff[ADDR_W];
      free_idx_r <= free_idx;
      no_free_r  <= no_free;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_valid) begin
      status_r       <= cmd.res_status;
      region_start_r <= '0;
      close_r        <= 1'b0;
      handle_r       <= '0;
      wb_r           <= 1'b0;
      if (cmd.res_status == ST_OK) begin
        if (func_r) begin
          close_r  <= exact;
          handle_r <= exact ? rd_data_r.file : '0;
          wb_r     <= rd_data_r.flags[0] && rd_data_r.prot[1];
        end else begin
          region_start_r <= nc_r;
        end
      end
    end
  end

  assign out_status           = status_r;
  assign out_region_start     = region_start_r;
  assign out_close_file       = close_r;
  assign out_closed_handle    = handle_r;
  assign out_writeback_needed = wb_r;

endmodule

@@ rtl/mrt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_ctrl
// Sequencer for map checks, the unmap slot scan and result handoff.
// ----------------------------------------------------------------------------
module mrt_ctrl
  import mrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  mrt_stat_t stat,
  output mrt_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MAP_CALC;
        end
      end
      S_MAP_CALC: begin
        if (stat.is_unmap) begin
          state_nxt = S_UN_READ;
        end else if (stat.denied) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_WRITE_DENIED;
          state_nxt      = S_DONE;
        end else begin
          cmd.calc  = 1'b1;
          state_nxt = S_MAP_CHECK;
        end
      end
      S_MAP_CHECK: begin
        cmd.res_valid = 1'b1;
        state_nxt     = S_DONE;
        if (stat.no_free) begin
          cmd.res_status = ST_NO_SLOT;
        end else if (stat.no_room) begin
          cmd.res_status = ST_NO_ROOM;
        end else begin
          cmd.map_commit = 1'b1;
        end
      end
      S_UN_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_UN_CHECK;
      end
      S_UN_CHECK: begin
        if (stat.hit) begin
          state_nxt = S_UN_UPDATE;
        end else if (stat.last) begin
          cmd.res_valid  = 1'b1;
          cmd.res_status = ST_NOT_MAPPED;
          state_nxt      = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_UN_READ;
        end
      end
      S_UN_UPDATE: begin
        cmd.unmap_commit = 1'b1;
        cmd.res_valid    = 1'b1;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/mapped_region_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapped_region_table_unit
// Table of mapped regions with a downward-growing map ceiling.
// ----------------------------------------------------------------------------
// One item is handled at a time. A map passes S_MAP_CALC and S_MAP_CHECK, or
// only S_MAP_CALC when refused for write permission. An unmap scans the slot
// store through its single registered read port, reading a slot in S_UN_READ
// and checking it in S_UN_CHECK; a matching slot is updated in S_UN_UPDATE.
// The result is held until taken; the next item is accepted in the cycle after.
module mapped_region_table_unit
  import mrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [LEN_W-1:0]  in_length,
  input  logic [PROT_W-1:0] in_protection,
  input  logic [FLAG_W-1:0] in_map_flags,
  input  logic              in_file_writable,
  input  logic [FILE_W-1:0] in_file_handle,
  input  logic [ADDR_W-1:0] in_heap_top,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_region_start,
  output logic              out_close_file,
  output logic [FILE_W-1:0] out_closed_handle,
  output logic              out_writeback_needed
);

  mrt_cmd_t  cmd;
  mrt_stat_t stat;

  mrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mrt_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_func              (in_func),
    .in_address           (in_address),
    .in_length            (in_length),
    .in_protection        (in_protection),
    .in_map_flags         (in_map_flags),
    .in_file_writable     (in_file_writable),
    .in_file_handle       (in_file_handle),
    .in_heap_top          (in_heap_top),
    .out_status           (out_status),
    .out_region_start     (out_region_start),
    .out_close_file       (out_close_file),
    .out_closed_handle    (out_closed_handle),
    .out_writeback_needed (out_writeback_needed)
  );

endmodule

@@ rtl/mrt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_checker
// Port-level checks for the mapped region table, bound to the top level.
// ----------------------------------------------------------------------------
module mrt_checker
  import mrt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [ADDR_W-1:0] out_region_start,
  input logic              out_close_file,
  input logic              out_writeback_needed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped or changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("new item taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("item finished in the cycle of its acceptance");

  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_region_start == '0 && !out_close_file && !out_writeback_needed)
    else $error("refused request carries result data");

endmodule

bind mapped_region_table_unit mrt_checker u_mrt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_status           (out_status),
  .out_region_start     (out_region_start),
  .out_close_file       (out_close_file),
  .out_writeback_needed (out_writeback_needed)
);
